[rtl/ckrs_pkg.sv]
// shared types and constants of the cross-kernel rgb sharpener
package ckrs_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MAX_HEIGHT    = 2048;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN         = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [3:0]  GAIN_RESET         = 4'd5;
    localparam logic [11:0] FRAME_WIDTH_RESET  = 12'd800;
    localparam logic [11:0] FRAME_HEIGHT_RESET = 12'd600;

    localparam int COORD_W = 11;
    localparam int SLOTS   = 3;

    localparam logic [1:0] SLOT_CENTER = 2'd0;
    localparam logic [1:0] SLOT_RIGHT  = 2'd1;
    localparam logic [1:0] SLOT_SELF   = 2'd2;

    // channel 0 red, 1 green, 2 blue
    typedef logic [2:0][7:0] rgb_t;

    typedef struct packed {
        rgb_t               pix;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } result_t;

    typedef struct packed {
        logic             load;
        logic [SLOTS-1:0] mask;
    } emit_ctrl_t;

endpackage

[rtl/cross_kernel_rgb_sharpen.sv]
// top level of the cross-kernel rgb sharpener
// Takes one raster-order RGB pixel per clock when not stalled and returns pixels sharpened
// per channel with gain*center - left - right - up - down, clamped to 0..255; the outer
// border of the frame passes through. Pixel (x-1,y-1) leaves when pixel (x,y) arrives, the
// last column one row late and the last row as it arrives, each with its column and row and
// run_end on the last result of an input item. An item passes the line-buffer read with the
// channel lanes, then the result register. One item enters per clock while in_stall is low;
// the output port sends one result per clock while out_stall is low, so items with two or
// three results hold the input until their last result is sent.
// Writing frame_width or frame_height restarts the frame; the line buffers need no clearing.
module cross_kernel_rgb_sharpen #(
    parameter int MAX_WIDTH = ckrs_pkg::MAX_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ckrs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ckrs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       red_in,
    input  logic [7:0]                       green_in,
    input  logic [7:0]                       blue_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       red_out,
    output logic [7:0]                       green_out,
    output logic [7:0]                       blue_out,
    output logic [10:0]                      pixel_col,
    output logic [10:0]                      pixel_row,
    output logic                             run_end
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > 12) ? WW : 12;

    logic [3:0]    gain_reg;
    logic [11:0]   frame_width_reg;
    logic [11:0]   frame_height_reg;
    logic [AW-1:0] col_count_reg;
    logic [AW-1:0] col_count_next;
    logic [10:0]   row_count_reg;
    logic [10:0]   row_count_next;

    ckrs_pkg::rgb_t win_c_reg;
    ckrs_pkg::rgb_t win_l_reg;
    ckrs_pkg::rgb_t win_u_reg;
    ckrs_pkg::rgb_t win_d_reg;

    logic           s1_valid_reg;
    logic           s1_valid_next;
    logic [AW-1:0]  s1_x_reg;
    logic [10:0]    s1_y_reg;
    ckrs_pkg::rgb_t s1_px_reg;
    logic           s1_emit_c_reg;
    logic           s1_pass_c_reg;
    logic           s1_emit_r_reg;
    logic           s1_emit_s_reg;
    logic           fwd_reg;
    ckrs_pkg::rgb_t fwd_data_reg;

    logic [CMPW-1:0] fw_ext;
    logic [CMPW-1:0] w_clamped;
    logic [CMPW-1:0] w_last_wide;
    logic [AW-1:0]   w_last;
    logic [11:0]     h_clamped;
    logic [11:0]     h_last_wide;
    logic [10:0]     h_last;

    logic           accept;
    logic           restart;
    logic           s1_go;
    logic           s2_free;
    logic           x_at_end;
    ckrs_pkg::rgb_t px;
    ckrs_pkg::rgb_t above;
    ckrs_pkg::rgb_t above2;
    logic [23:0]    prev_rdata;
    logic [23:0]    prev2_rdata;
    ckrs_pkg::rgb_t sharp;
    ckrs_pkg::rgb_t centre_pix;

    ckrs_pkg::emit_ctrl_t                        emit_ctrl;
    ckrs_pkg::result_t [ckrs_pkg::SLOTS-1:0]     slots;
    ckrs_pkg::result_t                           out_res;

    // geometry
    always_comb
    begin
        fw_ext = CMPW'(frame_width_reg);
        if (fw_ext == '0)
        begin
            w_clamped = CMPW'(1);
        end
        else if (fw_ext > CMPW'(MAX_WIDTH))
        begin
            w_clamped = CMPW'(MAX_WIDTH);
        end
        else
        begin
            w_clamped = fw_ext;
        end
        w_last_wide = w_clamped - CMPW'(1);
        w_last      = w_last_wide[AW-1:0];

        if (frame_height_reg == 12'd0)
        begin
            h_clamped = 12'd1;
        end
        else if (frame_height_reg > 12'(ckrs_pkg::MAX_HEIGHT))
        begin
            h_clamped = 12'(ckrs_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_clamped = frame_height_reg;
        end
        h_last_wide = h_clamped - 12'd1;
        h_last      = h_last_wide[10:0];
    end

    assign restart  = cfg_we && ((cfg_index == ckrs_pkg::REG_FRAME_WIDTH)
                                 || (cfg_index == ckrs_pkg::REG_FRAME_HEIGHT));
    assign s1_go    = s1_valid_reg && s2_free;
    assign in_stall = s1_valid_reg && !s2_free;
    assign accept   = in_valid && !in_stall;
    assign px       = {blue_in, green_in, red_in};
    assign x_at_end = (col_count_reg == w_last);

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (restart)
        begin
            col_count_next = '0;
            row_count_next = '0;
        end
        else if (accept)
        begin
            if (x_at_end)
            begin
                col_count_next = '0;
                row_count_next = (row_count_reg == h_last) ? 11'd0 : row_count_reg + 11'd1;
            end
            else
            begin
                col_count_next = col_count_reg + AW'(1);
            end
        end

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg         <= ckrs_pkg::GAIN_RESET;
            frame_width_reg  <= ckrs_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= ckrs_pkg::FRAME_HEIGHT_RESET;
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            fwd_reg          <= 1'b0;
            win_c_reg        <= '0;
            win_l_reg        <= '0;
            win_u_reg        <= '0;
            win_d_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ckrs_pkg::REG_GAIN:         gain_reg <= cfg_data[3:0];
                    ckrs_pkg::REG_FRAME_WIDTH:  frame_width_reg <= cfg_data;
                    ckrs_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    default:                    ;
                endcase
            end
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            s1_valid_reg  <= s1_valid_next;
            if (accept)
            begin
                fwd_reg <= s1_go && (s1_x_reg == col_count_reg);
            end
            if (restart)
            begin
                win_c_reg <= '0;
                win_l_reg <= '0;
                win_u_reg <= '0;
                win_d_reg <= '0;
            end
            else if (s1_go)
            begin
                win_l_reg <= win_c_reg;
                win_c_reg <= above;
                win_u_reg <= above2;
                win_d_reg <= s1_px_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg      <= col_count_reg;
            s1_y_reg      <= row_count_reg;
            s1_px_reg     <= px;
            s1_emit_c_reg <= (row_count_reg != 11'd0) && (col_count_reg != '0);
            s1_pass_c_reg <= (row_count_reg == 11'd1) || (col_count_reg == AW'(1));
            s1_emit_r_reg <= (row_count_reg != 11'd0) && x_at_end;
            s1_emit_s_reg <= (row_count_reg == h_last);
            fwd_data_reg  <= above;
        end
    end

    // line buffers: row y-1 and row y-2
    ckrs_ram #(
        .WIDTH (24),
        .DEPTH (MAX_WIDTH)
    ) u_line_prev (
        .clk   (clk),
        .we    (accept),
        .waddr (col_count_reg),
        .wdata (px),
        .re    (accept),
        .raddr (col_count_reg),
        .rdata (prev_rdata)
    );

    ckrs_ram #(
        .WIDTH (24),
        .DEPTH (MAX_WIDTH)
    ) u_line_prev2 (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_x_reg),
        .wdata (above),
        .re    (accept),
        .raddr (col_count_reg),
        .rdata (prev2_rdata)
    );

    assign above  = prev_rdata;
    assign above2 = fwd_reg ? fwd_data_reg : ckrs_pkg::rgb_t'(prev2_rdata);

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        ckrs_lane u_lane (
            .gain   (gain_reg),
            .centre (win_c_reg[k]),
            .left   (win_l_reg[k]),
            .right  (above[k]),
            .up     (win_u_reg[k]),
            .down   (win_d_reg[k]),
            .result (sharp[k])
        );
    end

    // merge lane results with pass-through pixels into the result slots
    always_comb
    begin
        centre_pix = s1_pass_c_reg ? win_c_reg : sharp;

        slots[ckrs_pkg::SLOT_CENTER].pix = centre_pix;
        slots[ckrs_pkg::SLOT_CENTER].col = 11'(s1_x_reg - AW'(1));
        slots[ckrs_pkg::SLOT_CENTER].row = s1_y_reg - 11'd1;
        slots[ckrs_pkg::SLOT_RIGHT].pix  = above;
        slots[ckrs_pkg::SLOT_RIGHT].col  = 11'(s1_x_reg);
        slots[ckrs_pkg::SLOT_RIGHT].row  = s1_y_reg - 11'd1;
        slots[ckrs_pkg::SLOT_SELF].pix   = s1_px_reg;
        slots[ckrs_pkg::SLOT_SELF].col   = 11'(s1_x_reg);
        slots[ckrs_pkg::SLOT_SELF].row   = s1_y_reg;

        emit_ctrl.load = s1_go;
        emit_ctrl.mask = {s1_emit_s_reg, s1_emit_r_reg, s1_emit_c_reg};
    end

    ckrs_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (emit_ctrl),
        .slots_in  (slots),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res),
        .run_end   (run_end),
        .free      (s2_free)
    );

    assign red_out   = out_res.pix[0];
    assign green_out = out_res.pix[1];
    assign blue_out  = out_res.pix[2];
    assign pixel_col = out_res.col;
    assign pixel_row = out_res.row;

    // counters stay inside the frame
    a_counters_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (col_count_reg <= w_last) && (row_count_reg <= h_last))
        else $error("pixel counters outside the frame");

    // an item waiting for the result stage is held
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> (s1_valid_reg && $stable(s1_x_reg) && $stable(s1_y_reg)))
        else $error("waiting item lost or changed");

    // a new item only enters when the read stage is free or draining
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!s1_valid_reg || s1_go))
        else $error("item overwrote the read stage");

endmodule

[rtl/ckrs_ram.sv]
// generic single-write, single-read ram with registered read
module ckrs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/ckrs_lane.sv]
// one channel of the cross kernel: gain*centre minus four neighbors, clamped
module ckrs_lane (
    input  logic [3:0] gain,
    input  logic [7:0] centre,
    input  logic [7:0] left,
    input  logic [7:0] right,
    input  logic [7:0] up,
    input  logic [7:0] down,
    output logic [7:0] result
);

    logic [11:0] prod;
    logic [9:0]  neigh_sum;
    logic [12:0] diff;

    always_comb
    begin
        prod      = 12'(gain) * 12'(centre);
        neigh_sum = 10'(left) + 10'(right) + 10'(up) + 10'(down);
        diff      = {1'b0, prod} - {3'b000, neigh_sum};
        if (diff[12])
        begin
            result = 8'd0;
        end
        else if (|diff[11:8])
        begin
            result = 8'd255;
        end
        else
        begin
            result = diff[7:0];
        end
    end

endmodule

[rtl/ckrs_emit.sv]
// result stage: holds up to three results of one item and sends them in order
module ckrs_emit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ckrs_pkg::emit_ctrl_t                 ctrl,
    input  ckrs_pkg::result_t [ckrs_pkg::SLOTS-1:0] slots_in,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output ckrs_pkg::result_t                    out_res,
    output logic                                 run_end,
    output logic                                 free
);

    logic [ckrs_pkg::SLOTS-1:0]                 mask_reg;
    logic [ckrs_pkg::SLOTS-1:0]                 mask_next;
    ckrs_pkg::result_t [ckrs_pkg::SLOTS-1:0]    slot_reg;
    logic [1:0]                                 sel;
    logic [ckrs_pkg::SLOTS-1:0]                 sel_onehot;
    logic [ckrs_pkg::SLOTS-1:0]                 mask_left;
    logic [ckrs_pkg::SLOTS-1:0]                 mask_after;
    logic                                       fire;

    always_comb
    begin
        if (mask_reg[0])
        begin
            sel = ckrs_pkg::SLOT_CENTER;
        end
        else if (mask_reg[1])
        begin
            sel = ckrs_pkg::SLOT_RIGHT;
        end
        else
        begin
            sel = ckrs_pkg::SLOT_SELF;
        end
        sel_onehot = ckrs_pkg::SLOTS'(1) << sel;
        mask_left  = mask_reg & ~sel_onehot;
        out_valid  = |mask_reg;
        out_res    = slot_reg[sel];
        run_end    = (mask_left == '0);
        fire       = out_valid && !out_stall;
        mask_after = fire ? mask_left : mask_reg;
        free       = (mask_after == '0);
        mask_next  = ctrl.load ? ctrl.mask : mask_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            slot_reg <= slots_in;
        end
    end

endmodule
